### rtl/core/hpt_pkg.sv
// Shared constants and codes of the homogeneous point transform.
package hpt_pkg;

	// Default fixed-point format: signed Q16.16.
	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Number of stored matrix coefficients (4x4, row major).
	localparam int COEFF_COUNT = 16;

	// Transaction kinds on the input channel.
	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_XFORM = 1'b1
	} action_t;

endpackage

### rtl/core/homogeneous_point_transform.sv
// Pipelined 4x4 homogeneous point transform with perspective divide.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  input   | in_valid, in_stall | action, coeff_index, coeff_value, point_x/y/z
//  output  | out_valid,out_stall| out_x, out_y, out_z, w_zero, saturated
//
// One transaction is accepted every clock while the output is not stalled.
// A point result passes the product, sum, dot-product, magnitude and scaling
// stages, then the restoring divider, one quotient bit per stage, and the output register.
// A coefficient load writes the matrix at once and yields no result.
// Reset loads the identity matrix and empties the pipeline.
// A stalled result freezes the whole pipeline and stalls the input.
module homogeneous_point_transform #(
	parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = hpt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [3:0]                    coeff_index,
	input  logic signed [VALUE_WIDTH-1:0] coeff_value,
	input  logic signed [VALUE_WIDTH-1:0] point_x,
	input  logic signed [VALUE_WIDTH-1:0] point_y,
	input  logic signed [VALUE_WIDTH-1:0] point_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] out_x,
	output logic signed [VALUE_WIDTH-1:0] out_y,
	output logic signed [VALUE_WIDTH-1:0] out_z,
	output logic                          w_zero,
	output logic                          saturated
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = 2 * W + FRAC_BITS + 2;     // exact dot product width
	localparam int NW = AW + FRAC_BITS;            // scaled numerator width
	localparam int HW = NW - W;                    // numerator above the quotient bits
	localparam int CW = (HW > AW) ? HW : AW;       // overflow compare width
	localparam int NC = hpt_pkg::COEFF_COUNT;

	logic signed [W-1:0] mtx_q [NC];
	logic signed [W-1:0] pt [3];
	logic                en;
	logic                acc_load;
	logic                acc_xform;

	// The pipeline moves as one unless a result at the output is stalled.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign acc_load  = in_valid && en && (action == hpt_pkg::ACT_LOAD);
	assign acc_xform = in_valid && en && (action == hpt_pkg::ACT_XFORM);

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// Coefficient store, reset to the identity matrix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				mtx_q[i] <= (i % 5 == 0) ? (W'(1) << FRAC_BITS) : '0;
			end
		end else if (acc_load) begin
			mtx_q[coeff_index] <= coeff_value;
		end
	end

	// Stage 1: coefficient products; the translation column is only shifted.
	logic signed [2*W-1:0] prod [4][3];
	logic signed [AW-1:0]  term_s1 [4][4];
	logic                  vld_s1;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod[r][c] = mtx_q[r*4+c] * pt[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					term_s1[r][c] <= AW'(prod[r][c]);
				end
				term_s1[r][3] <= AW'(mtx_q[r*4+3]) <<< FRAC_BITS;
			end
		end
	end

	// Stage 2: pairwise sums of each row.
	logic signed [AW-1:0] suma_s2 [4];
	logic signed [AW-1:0] sumb_s2 [4];
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				suma_s2[r] <= term_s1[r][0] + term_s1[r][1];
				sumb_s2[r] <= term_s1[r][2] + term_s1[r][3];
			end
		end
	end

	// Stage 3: full dot products x', y', z', w'.
	logic signed [AW-1:0] acc_s3 [4];
	logic                 vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				acc_s3[r] <= suma_s2[r] + sumb_s2[r];
			end
		end
	end

	// Stage 4: magnitudes, signs and the zero test on w'.
	logic [AW-1:0] mag_s4 [4];
	logic [3:0]    sgn_s4;
	logic          wz_s4;
	logic          vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				mag_s4[r] <= acc_s3[r][AW-1] ? AW'(-acc_s3[r]) : AW'(acc_s3[r]);
				sgn_s4[r] <= acc_s3[r][AW-1];
			end
			wz_s4 <= (acc_s3[3] == '0);
		end
	end

	// Divider pipeline: entry 0 is stage 5, entry k holds k quotient steps done.
	logic [AW-1:0] dv_rem_s5 [W+1][3];
	logic [W-1:0]  dv_nq_s5  [W+1][3];
	logic [2:0]    dv_ovf_s5 [W+1];
	logic [2:0]    dv_neg_s5 [W+1];
	logic [AW-1:0] dv_den_s5 [W+1];
	logic          dv_wz_s5  [W+1];
	logic          dv_vld_s5 [W+1];

	// Stage 5: scale the numerator, catch quotients of 2^W or more.
	logic [NW-1:0] num   [3];
	logic [HW-1:0] numhi [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			num[r]   = NW'(mag_s4[r]) << FRAC_BITS;
			numhi[r] = num[r][NW-1:W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				dv_rem_s5[0][r] <= AW'(numhi[r]);
				dv_nq_s5[0][r]  <= num[r][W-1:0];
				dv_ovf_s5[0][r] <= (CW'(numhi[r]) >= CW'(mag_s4[3]));
				dv_neg_s5[0][r] <= sgn_s4[r] ^ sgn_s4[3];
			end
			dv_den_s5[0] <= mag_s4[3];
			dv_wz_s5[0]  <= wz_s4;
		end
	end

	// One restoring step per stage; numerator bits shift out as quotient bits shift in.
	for (genvar k = 0; k < W; k++) begin : g_div
		logic [AW:0] trial [3];
		logic [2:0]  ge;

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				trial[r] = {dv_rem_s5[k][r], dv_nq_s5[k][r][W-1]};
				ge[r]    = (trial[r] >= {1'b0, dv_den_s5[k]});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int r = 0; r < 3; r++) begin
					dv_rem_s5[k+1][r] <= ge[r] ? AW'(trial[r] - {1'b0, dv_den_s5[k]})
					                           : AW'(trial[r]);
					dv_nq_s5[k+1][r]  <= {dv_nq_s5[k][r][W-2:0], ge[r]};
				end
				dv_ovf_s5[k+1] <= dv_ovf_s5[k];
				dv_neg_s5[k+1] <= dv_neg_s5[k];
				dv_den_s5[k+1] <= dv_den_s5[k];
				dv_wz_s5[k+1]  <= dv_wz_s5[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s5[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s5[k+1] <= dv_vld_s5[k];
			end
		end
	end

	// Final stage: clamp, restore the sign, force zero when w' is zero.
	logic [W-1:0] lim   [3];
	logic [W-1:0] qsel  [3];
	logic [W-1:0] res   [3];
	logic [2:0]   clamp;
	logic [W-1:0] out_q [3];
	logic         wz_q;
	logic         sat_q;
	logic         vld_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lim[r]   = dv_neg_s5[W][r] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
			clamp[r] = dv_ovf_s5[W][r] || (dv_nq_s5[W][r] > lim[r]);
			qsel[r]  = clamp[r] ? lim[r] : dv_nq_s5[W][r];
			res[r]   = dv_neg_s5[W][r] ? (W'(0) - qsel[r]) : qsel[r];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				out_q[r] <= dv_wz_s5[W] ? '0 : res[r];
			end
			wz_q  <= dv_wz_s5[W];
			sat_q <= !dv_wz_s5[W] && (clamp != 3'b000);
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			dv_vld_s5[0] <= 1'b0;
			vld_q        <= 1'b0;
		end else if (en) begin
			vld_s1       <= acc_xform;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			dv_vld_s5[0] <= vld_s4;
			vld_q        <= dv_vld_s5[W];
		end
	end

	assign out_valid = vld_q;
	assign out_x     = out_q[0];
	assign out_y     = out_q[1];
	assign out_z     = out_q[2];
	assign w_zero    = wz_q;
	assign saturated = sat_q;

`ifndef ASSERT_OFF
	// A zero w' result carries zero coordinates and no clamp flag.
	a_wzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !saturated)
		else $error("w_zero result with nonzero payload");

	// A coefficient load never enters the arithmetic pipeline.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> !vld_s1)
		else $error("load transaction entered the pipeline");

	// An accepted load is visible in the store on the next cycle.
	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> mtx_q[$past(coeff_index)] == $past(coeff_value))
		else $error("coefficient store not updated");

	// A frozen pipeline keeps its stage-1 and divider entry valid bits.
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> dv_vld_s5[0] == $past(dv_vld_s5[0]) && vld_s1 == $past(vld_s1))
		else $error("pipeline moved while stalled");
`endif

endmodule

### tb/tb.sv
// Testbench for the homogeneous point transform, checked against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = hpt_pkg::VALUE_WIDTH_DEF;
	localparam int FB = hpt_pkg::FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = VW + 20;

	typedef logic signed [VW-1:0] value_t;

	typedef struct {
		value_t x;
		value_t y;
		value_t z;
		logic   w_zero;
		logic   saturated;
	} point_result_t;

	// Scoreboard: keeps the matrix copy and the queue of predicted point results.
	class point_scoreboard;
		value_t        coeffs[hpt_pkg::COEFF_COUNT];
		point_result_t awaited[$];
		int            mismatches;

		function new();
			foreach (coeffs[i]) coeffs[i] = (i % 5 == 0) ? value_t'(1 << FB) : '0;
			mismatches = 0;
		endfunction

		// Fixed-point quotient of num/den truncated toward zero, clamped to the value range.
		function automatic value_t divide_clamped(logic signed [127:0] num,
				logic signed [127:0] den, ref logic sat);
			logic [127:0] n_mag, d_mag, quo, lim;
			logic         neg;
			neg = num[127] ^ den[127];
			n_mag = num[127] ? -num : num;
			d_mag = den[127] ? -den : den;
			quo = (n_mag << FB) / d_mag;
			lim = neg ? (128'd1 << (VW - 1)) : ((128'd1 << (VW - 1)) - 1);
			if (quo > lim) begin
				sat = 1'b1;
				quo = lim;
			end
			return neg ? value_t'(-quo) : value_t'(quo);
		endfunction

		// Note one accepted input transaction and predict its result, if any.
		function void note_input(hpt_pkg::action_t act, logic [3:0] idx, value_t cval,
				value_t px, value_t py, value_t pz);
			logic signed [127:0] pt[4];
			logic signed [127:0] acc[4];
			logic signed [127:0] c_ext;
			point_result_t       res;
			logic                sat;
			if (act == hpt_pkg::ACT_LOAD) begin
				coeffs[idx] = cval;
				return;
			end
			pt[0] = px;
			pt[1] = py;
			pt[2] = pz;
			pt[3] = 128'sd1 << FB;
			for (int r = 0; r < 4; r++) begin
				acc[r] = '0;
				for (int c = 0; c < 4; c++) begin
					c_ext = coeffs[r * 4 + c];
					acc[r] = acc[r] + c_ext * pt[c];
				end
			end
			sat = 1'b0;
			if (acc[3] == 0) begin
				res = '{x: '0, y: '0, z: '0, w_zero: 1'b1, saturated: 1'b0};
			end else begin
				res.x = divide_clamped(acc[0], acc[3], sat);
				res.y = divide_clamped(acc[1], acc[3], sat);
				res.z = divide_clamped(acc[2], acc[3], sat);
				res.w_zero = 1'b0;
				res.saturated = sat;
			end
			awaited.push_back(res);
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_result(point_result_t got);
			point_result_t exp_res;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result x=%h y=%h z=%h", got.x, got.y, got.z);
				return;
			end
			exp_res = awaited.pop_front();
			if (got.x !== exp_res.x || got.y !== exp_res.y || got.z !== exp_res.z ||
					got.w_zero !== exp_res.w_zero || got.saturated !== exp_res.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: exp x=%h y=%h z=%h wz=%b sat=%b, got x=%h y=%h z=%h wz=%b sat=%b",
						exp_res.x, exp_res.y, exp_res.z, exp_res.w_zero, exp_res.saturated,
						got.x, got.y, got.z, got.w_zero, got.saturated);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       action;
	logic [3:0] coeff_index;
	value_t     coeff_value;
	value_t     point_x;
	value_t     point_y;
	value_t     point_z;
	logic       out_valid;
	logic       out_stall;
	value_t     out_x;
	value_t     out_y;
	value_t     out_z;
	logic       w_zero;
	logic       saturated;

	point_scoreboard sb;
	bit              quiet;
	int              idle_cycles;

	homogeneous_point_transform u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .coeff_index(coeff_index), .coeff_value(coeff_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.w_zero(w_zero), .saturated(saturated)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver stalls at random except during the quiet stretch.
	always @(posedge clk) begin
		out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 14);
	end

	// Monitors on both channels, plus the watchdog on lack of progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(hpt_pkg::action_t'(action), coeff_index, coeff_value,
					point_x, point_y, point_z);
			if (out_valid && !out_stall)
				sb.check_result('{x: out_x, y: out_y, z: out_z,
					w_zero: w_zero, saturated: saturated});
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Mostly small values of a few units, sometimes full range or an extreme.
	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0, 1: return value_t'($urandom);
			2: return $urandom_range(0, 1) ? value_t'({1'b0, {(VW-1){1'b1}}}) :
				value_t'({1'b1, {(VW-1){1'b0}}});
			default: return value_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	// Send one transaction and hold it until accepted.
	task automatic send_item(hpt_pkg::action_t act, logic [3:0] idx, value_t cval,
			value_t px, value_t py, value_t pz);
		in_valid <= 1'b1;
		action <= act;
		coeff_index <= idx;
		coeff_value <= cval;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_coeff(logic [3:0] idx, value_t cval);
		send_item(hpt_pkg::ACT_LOAD, idx, cval, pick_value(), pick_value(), pick_value());
	endtask

	task automatic send_point(value_t px, value_t py, value_t pz);
		send_item(hpt_pkg::ACT_XFORM, 4'($urandom), value_t'($urandom), px, py, pz);
	endtask

	// Random gap between transactions unless in the quiet stretch.
	task automatic maybe_idle();
		while (!quiet && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	localparam value_t VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam value_t ONE = 1 << FB;

	initial begin
		sb = new();
		quiet = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		action = hpt_pkg::ACT_LOAD;
		coeff_index = '0;
		coeff_value = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity matrix after reset passes points through, extremes included.
		send_point('0, '0, '0);
		send_point(VMAX, VMIN, ONE);
		send_point(VMIN, VMAX, -ONE);
		// Zero w row gives the zero-w flag.
		load_coeff(4'd15, '0);
		send_point(ONE, ONE, ONE);
		// Tiny w makes quotients overflow in both directions.
		load_coeff(4'd15, value_t'(1));
		send_point(VMAX, VMIN, ONE);
		// Negative w flips signs.
		load_coeff(4'd15, -ONE);
		send_point(ONE, -ONE, VMAX);
		// Write every coefficient once, then transform.
		for (int i = 0; i < hpt_pkg::COEFF_COUNT; i++)
			load_coeff(4'(i), (i % 5 == 0) ? ONE : pick_value());
		send_point(pick_value(), pick_value(), pick_value());

		// Random traffic, with a drain pause and a stretch without idling.
		for (int n = 0; n < 1300; n++) begin
			quiet = (n >= 400 && n < 600);
			if (n == 800) begin
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			maybe_idle();
			case ($urandom_range(0, 99)) inside
				[0:2]: begin
					// Rewrite the w row: zero, or a plain unit w.
					for (int c = 12; c < 16; c++)
						load_coeff(4'(c), ($urandom_range(0, 1) || c != 15) ? '0 : ONE);
				end
				[3:19]: load_coeff(4'($urandom), pick_value());
				default: send_point(pick_value(), pick_value(), pick_value());
			endcase
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
